### rtl/prc_pkg.sv
// Shared types and codes for the polygon rectangle clipper.
// No dependencies.
package prc_pkg;

   // Classification attached to each queued vertex by the front end.
   typedef struct packed {
      logic final_v;   // closes the polygon
      logic drop;      // store was full, vertex discarded
      logic ovf;       // polygon has lost a vertex so far
   } item_ctrl_type;

   localparam int CTRL_BITS = $bits(item_ctrl_type);

   // Clip pass order: bottom, right, top, left.
   localparam logic [1:0] SIDE_BOTTOM = 2'd0;
   localparam logic [1:0] SIDE_RIGHT  = 2'd1;
   localparam logic [1:0] SIDE_TOP    = 2'd2;
   localparam logic [1:0] SIDE_LEFT   = 2'd3;

   // Rectangle register indexes.
   localparam logic [1:0] REG_MIN_X = 2'd0;
   localparam logic [1:0] REG_MIN_Y = 2'd1;
   localparam logic [1:0] REG_MAX_X = 2'd2;
   localparam logic [1:0] REG_MAX_Y = 2'd3;

endpackage

### rtl/prc_front.sv
// Front end: accepts vertex transactions, assigns store slots, flags overflow.
// Depends on prc_pkg.
module prc_front #(
   parameter int MAX_VERTS  = 32,
   parameter int COORD_BITS = 16,
   parameter int CW         = 6,
   parameter int AW         = 5,
   parameter int DW         = 2 * COORD_BITS + AW + prc_pkg::CTRL_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic signed [COORD_BITS-1:0] vx,
   input  logic signed [COORD_BITS-1:0] vy,
   input  logic                         vfinal,
   output logic                         push,
   output logic [DW-1:0]                push_data
);
   import prc_pkg::*;

   logic [CW-1:0] count_ff, count_in;
   logic          sticky_ff, sticky_in;
   item_ctrl_type ctrl;

   always_comb begin
      ctrl.drop    = (count_ff == CW'(MAX_VERTS));
      ctrl.final_v = vfinal;
      ctrl.ovf     = sticky_ff | ctrl.drop;
      count_in     = count_ff;
      sticky_in    = sticky_ff;
      if (take) begin
         if (vfinal) begin
            count_in  = '0;
            sticky_in = 1'b0;
         end else begin
            sticky_in = ctrl.ovf;
            if (!ctrl.drop) count_in = count_ff + CW'(1);
         end
      end
   end

   assign push      = take;
   assign push_data = {vx, vy, count_ff[AW-1:0], ctrl};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sticky_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end
endmodule

### rtl/prc_fifo.sv
// Two-entry queue between front end and clip engine.
// No dependencies.
module prc_fifo #(
   parameter int DW = 40
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] wdata,
   input  logic          pop,
   output logic [DW-1:0] rdata,
   output logic          full,
   output logic          empty
);
   logic [DW-1:0] slot_ff [2];
   logic          wptr_ff, rptr_ff;
   logic [1:0]    cnt_ff;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop)  rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

### rtl/prc_interp.sv
// Edge/bound intersection: p0 + (p1-p0)*(bnd-co)/(no-co), rounded half away
// from zero. One multiply, then a restoring divide one quotient bit per cycle.
module prc_interp #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [COORD_BITS-1:0] p0,
   input  logic signed [COORD_BITS-1:0] p1,
   input  logic signed [COORD_BITS-1:0] bnd,
   input  logic signed [COORD_BITS-1:0] co,
   input  logic signed [COORD_BITS-1:0] no,
   output logic                         done,
   output logic signed [COORD_BITS-1:0] result
);
   localparam int C  = COORD_BITS;
   localparam int KW = $clog2(C + 2);

   localparam logic [1:0] I_IDLE = 2'd0;
   localparam logic [1:0] I_MUL  = 2'd1;
   localparam logic [1:0] I_DIV  = 2'd2;
   localparam logic [1:0] I_FIN  = 2'd3;

   logic [1:0]          state_ff;
   logic [C:0]          a_ff, b_ff, d_ff, q_ff;
   logic                neg_ff, loaded_ff;
   logic signed [C-1:0] p0_ff;
   logic [2*C+1:0]      prod_ff;
   logic [C+1:0]        rem_ff;
   logic [C:0]          low_ff;
   logic [KW-1:0]       k_ff;

   logic signed [C:0] diff, num, den;
   logic [2*C+2:0]    dividend;
   logic [C+2:0]      t, v, tsub;
   logic signed [C:0] sum;

   always_comb begin
      diff     = {p1[C-1], p1} - {p0[C-1], p0};
      num      = {bnd[C-1], bnd} - {co[C-1], co};
      den      = {no[C-1], no} - {co[C-1], co};
      dividend = {prod_ff, 1'b0} + {{(C+2){1'b0}}, d_ff};
      t        = {rem_ff, low_ff[C]};
      v        = {1'b0, d_ff, 1'b0};
      tsub     = t - v;
      sum      = neg_ff ? ({p0_ff[C-1], p0_ff} - $signed(q_ff))
                        : ({p0_ff[C-1], p0_ff} + $signed(q_ff));
   end

   assign done   = (state_ff == I_FIN);
   assign result = sum[C-1:0];

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= diff[C] ? (~diff + 1'b1) : diff;
         b_ff   <= num[C] ? (~num + 1'b1) : num;
         d_ff   <= den[C] ? (~den + 1'b1) : den;
         neg_ff <= diff[C] ^ num[C] ^ den[C];
         p0_ff  <= p0;
      end
      if (state_ff == I_MUL) begin
         if (!loaded_ff) begin
            prod_ff <= a_ff * b_ff;
         end else begin
            // 2ab + d, high part already below the doubled divisor
            rem_ff <= dividend[2*C+2:C+1];
            low_ff <= dividend[C:0];
            q_ff   <= '0;
            k_ff   <= KW'(C + 1);
         end
      end
      if (state_ff == I_DIV) begin
         if (t >= v) rem_ff <= tsub[C+1:0];
         else        rem_ff <= t[C+1:0];
         q_ff   <= {q_ff[C-1:0], (t >= v)};
         low_ff <= {low_ff[C-1:0], 1'b0};
         k_ff   <= k_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= I_IDLE;
         loaded_ff <= 1'b0;
      end else begin
         case (state_ff)
            I_IDLE: begin
               loaded_ff <= 1'b0;
               if (start) state_ff <= I_MUL;
            end
            I_MUL: begin
               loaded_ff <= 1'b1;
               if (loaded_ff) state_ff <= I_DIV;
            end
            I_DIV: begin
               if (k_ff == KW'(1)) state_ff <= I_FIN;
            end
            I_FIN: state_ff <= I_IDLE;
            default: state_ff <= I_IDLE;
         endcase
      end
   end
endmodule

### rtl/prc_back.sv
// Clip engine: loads the ping-pong vertex stores, runs four clip passes,
// streams the result. Depends on prc_pkg, prc_interp.
module prc_back #(
   parameter int MAX_VERTS  = 32,
   parameter int COORD_BITS = 16,
   parameter int CW         = 6,
   parameter int AW         = 5,
   parameter int DW         = 2 * COORD_BITS + AW + prc_pkg::CTRL_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] min_x,
   input  logic signed [COORD_BITS-1:0] min_y,
   input  logic signed [COORD_BITS-1:0] max_x,
   input  logic signed [COORD_BITS-1:0] max_y,
   input  logic                         q_empty,
   input  logic [DW-1:0]                q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_x,
   output logic signed [COORD_BITS-1:0] rsp_y,
   output logic                         rsp_last,
   output logic                         rsp_empty,
   output logic                         rsp_ovf
);
   import prc_pkg::*;

   localparam int C = COORD_BITS;

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_PSTART = 4'd1;
   localparam logic [3:0] S_FIRST  = 4'd2;
   localparam logic [3:0] S_NEXT   = 4'd3;
   localparam logic [3:0] S_EVAL   = 4'd4;
   localparam logic [3:0] S_INTERP = 4'd5;
   localparam logic [3:0] S_PEND   = 4'd6;
   localparam logic [3:0] S_ERD    = 4'd7;
   localparam logic [3:0] S_EOUT   = 4'd8;

   // stores
   logic [2*C-1:0] mem_a [MAX_VERTS];
   logic [2*C-1:0] mem_b [MAX_VERTS];
   logic [2*C-1:0] rd_a_ff, rd_b_ff, wdata;
   logic [AW-1:0]  raddr, waddr;
   logic           we_a, we_b;

   always_ff @(posedge clock) begin
      if (we_a) mem_a[waddr] <= wdata;
      rd_a_ff <= mem_a[raddr];
   end
   always_ff @(posedge clock) begin
      if (we_b) mem_b[waddr] <= wdata;
      rd_b_ff <= mem_b[raddr];
   end

   logic [3:0]    state_ff, state_in;
   logic [1:0]    pass_ff, pass_in;
   logic [CW-1:0] n_ff, n_in, cnt_ff, cnt_in, i_ff, i_in, ip1;
   logic          ovf_ff, ovf_in, use_first_ff, use_first_in;
   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [C-1:0] nx_x_ff, nx_x_in, nx_y_ff, nx_y_in;
   logic signed [C-1:0] fix_ff, fix_in;
   logic          rv_ff, rv_in, rl_ff, rl_in, re_ff, re_in, ro_ff, ro_in;
   logic signed [C-1:0] rx_ff, rx_in, ry_ff, ry_in;

   logic signed [C-1:0] qx, qy, sx, sy, nx, ny, bound, px, py;
   logic [AW-1:0]       qidx;
   item_ctrl_type       qctrl;
   logic [2*C-1:0]      src;
   logic                horiz, c_in, n_in_side, push_v, istart, idone;
   logic signed [C-1:0] ires;

   assign {qx, qy, qidx, qctrl} = q_data;
   assign src   = pass_ff[0] ? rd_b_ff : rd_a_ff;
   assign sx    = src[2*C-1:C];
   assign sy    = src[C-1:0];
   assign horiz = ~pass_ff[0];
   assign ip1   = i_ff + CW'(1);
   assign nx    = use_first_ff ? first_x_ff : sx;
   assign ny    = use_first_ff ? first_y_ff : sy;

   always_comb begin
      case (pass_ff)
         SIDE_BOTTOM: begin
            bound     = min_y;
            c_in      = cur_y_ff >= min_y;
            n_in_side = ny >= min_y;
         end
         SIDE_RIGHT: begin
            bound     = max_x;
            c_in      = cur_x_ff <= max_x;
            n_in_side = nx <= max_x;
         end
         SIDE_TOP: begin
            bound     = max_y;
            c_in      = cur_y_ff <= max_y;
            n_in_side = ny <= max_y;
         end
         default: begin
            bound     = min_x;
            c_in      = cur_x_ff >= min_x;
            n_in_side = nx >= min_x;
         end
      endcase
   end

   prc_interp #(.COORD_BITS(C)) u_interp (
      .clock  (clock),
      .reset  (reset),
      .start  (istart),
      .p0     (horiz ? cur_x_ff : cur_y_ff),
      .p1     (horiz ? nx : ny),
      .bnd    (bound),
      .co     (horiz ? cur_y_ff : cur_x_ff),
      .no     (horiz ? ny : nx),
      .done   (idone),
      .result (ires)
   );

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      i_in         = i_ff;
      ovf_in       = ovf_ff;
      use_first_in = use_first_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      nx_x_in      = nx_x_ff;
      nx_y_in      = nx_y_ff;
      fix_in       = fix_ff;
      rv_in        = 1'b0;
      rl_in        = rl_ff;
      re_in        = re_ff;
      ro_in        = ro_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      q_pop        = 1'b0;
      raddr        = i_ff[AW-1:0];
      waddr        = cnt_ff[AW-1:0];
      wdata        = '0;
      we_a         = 1'b0;
      we_b         = 1'b0;
      istart       = 1'b0;
      push_v       = 1'b0;
      px           = cur_x_ff;
      py           = cur_y_ff;

      case (state_ff)
         S_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               waddr = qidx;
               wdata = {qx, qy};
               we_a  = ~qctrl.drop;
               if (qctrl.final_v) begin
                  n_in     = qctrl.drop ? CW'(MAX_VERTS) : (CW'(qidx) + CW'(1));
                  ovf_in   = qctrl.ovf;
                  pass_in  = SIDE_BOTTOM;
                  state_in = S_PSTART;
               end
            end
         end
         S_PSTART: begin
            cnt_in = '0;
            i_in   = '0;
            raddr  = '0;
            state_in = (n_ff == '0) ? S_PEND : S_FIRST;
         end
         S_FIRST: begin
            first_x_in = sx;
            first_y_in = sy;
            cur_x_in   = sx;
            cur_y_in   = sy;
            state_in   = S_NEXT;
         end
         S_NEXT: begin
            raddr        = ip1[AW-1:0];
            use_first_in = ~(ip1 < n_ff);
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            nx_x_in = nx;
            nx_y_in = ny;
            fix_in  = bound;
            push_v  = c_in;
            if (c_in != n_in_side) begin
               istart   = 1'b1;
               state_in = S_INTERP;
            end else begin
               cur_x_in = nx;
               cur_y_in = ny;
               i_in     = ip1;
               state_in = (ip1 == n_ff) ? S_PEND : S_NEXT;
            end
         end
         S_INTERP: begin
            if (idone) begin
               push_v   = 1'b1;
               px       = horiz ? ires : fix_ff;
               py       = horiz ? fix_ff : ires;
               cur_x_in = nx_x_ff;
               cur_y_in = nx_y_ff;
               i_in     = ip1;
               state_in = (ip1 == n_ff) ? S_PEND : S_NEXT;
            end
         end
         S_PEND: begin
            n_in    = cnt_ff;
            pass_in = pass_ff + 2'd1;
            i_in    = '0;
            if (pass_ff != SIDE_LEFT) begin
               state_in = S_PSTART;
            end else if (cnt_ff == '0) begin
               // nothing survived: one empty transaction
               rv_in    = 1'b1;
               rx_in    = '0;
               ry_in    = '0;
               rl_in    = 1'b1;
               re_in    = 1'b1;
               ro_in    = ovf_ff;
               state_in = S_LOAD;
            end else begin
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            rv_in    = 1'b1;
            rx_in    = rd_a_ff[2*C-1:C];
            ry_in    = rd_a_ff[C-1:0];
            rl_in    = (ip1 == n_ff);
            re_in    = 1'b0;
            ro_in    = ovf_ff;
            i_in     = ip1;
            state_in = (ip1 == n_ff) ? S_LOAD : S_ERD;
         end
         default: state_in = S_LOAD;
      endcase

      // pass output into the destination store, dropping beyond capacity
      if (push_v) begin
         if (cnt_ff < CW'(MAX_VERTS)) begin
            wdata  = {px, py};
            we_a   = pass_ff[0];
            we_b   = ~pass_ff[0];
            cnt_in = cnt_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pass_ff      <= pass_in;
      n_ff         <= n_in;
      cnt_ff       <= cnt_in;
      i_ff         <= i_in;
      ovf_ff       <= ovf_in;
      use_first_ff <= use_first_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      first_x_ff   <= first_x_in;
      first_y_ff   <= first_y_in;
      nx_x_ff      <= nx_x_in;
      nx_y_ff      <= nx_y_in;
      fix_ff       <= fix_in;
      rl_ff        <= rl_in;
      re_ff        <= re_in;
      ro_ff        <= ro_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_x     = rx_ff;
   assign rsp_y     = ry_ff;
   assign rsp_last  = rl_ff;
   assign rsp_empty = re_ff;
   assign rsp_ovf   = ro_ff;
endmodule

### rtl/polygon_rect_clipper.sv
// A vertex transaction is accepted whenever the queue has room; after the last vertex the
// clip engine runs four clip passes, sending each crossing edge through the bit-serial
// divider, then emits the surviving vertices, or one empty result when nothing survives.
// Reset is synchronous and active high; bounds return to defaults, vertex stores are not
// cleared. The receiver cannot stall: results are strobes.
module polygon_rect_clipper #(
   parameter int MAX_VERTS  = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // vertex transactions
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic                         req_is_final_vertex,
   // clipped vertex transactions
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_out_last,
   output logic                         rsp_clipped_empty,
   output logic                         rsp_overflowed,
   // rectangle registers
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata
);
   import prc_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int AW = $clog2(MAX_VERTS);
   localparam int DW = 2 * C + AW + CTRL_BITS;

   // Rectangle bounds; max bounds reset to the largest positive coordinate.
   logic signed [C-1:0] min_x_ff, min_y_ff, max_x_ff, max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff <= '0;
         min_y_ff <= '0;
         max_x_ff <= {1'b0, {(C-1){1'b1}}};
         max_y_ff <= {1'b0, {(C-1){1'b1}}};
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_X: min_x_ff <= csr_wdata;  // left bound
            REG_MIN_Y: min_y_ff <= csr_wdata;  // bottom bound
            REG_MAX_X: max_x_ff <= csr_wdata;  // right bound
            REG_MAX_Y: max_y_ff <= csr_wdata;  // top bound
            default: ;
         endcase
      end
   end

   logic          take, push, q_full, q_empty, q_pop;
   logic [DW-1:0] push_data, q_data;

   // Accept whenever the queue has room; the engine drains it between polygons.
   assign busy = q_full;
   assign take = start & ~q_full;

   prc_front #(
      .MAX_VERTS(MAX_VERTS), .COORD_BITS(C), .CW(CW), .AW(AW), .DW(DW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .vx        (req_vertex_x),
      .vy        (req_vertex_y),
      .vfinal    (req_is_final_vertex),
      .push      (push),
      .push_data (push_data)
   );

   prc_fifo #(.DW(DW)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (push_data),
      .pop   (q_pop),
      .rdata (q_data),
      .full  (q_full),
      .empty (q_empty)
   );

   prc_back #(
      .MAX_VERTS(MAX_VERTS), .COORD_BITS(C), .CW(CW), .AW(AW), .DW(DW)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .min_x     (min_x_ff),
      .min_y     (min_y_ff),
      .max_x     (max_x_ff),
      .max_y     (max_y_ff),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_x     (rsp_out_x),
      .rsp_y     (rsp_out_y),
      .rsp_last  (rsp_out_last),
      .rsp_empty (rsp_clipped_empty),
      .rsp_ovf   (rsp_overflowed)
   );
endmodule

### rtl/prc_checker.sv
// Port-level checks for polygon_rect_clipper, bound to the top level.
// No dependencies.
module prc_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic [COORD_BITS-1:0] rsp_out_x,
   input logic [COORD_BITS-1:0] rsp_out_y,
   input logic                  rsp_out_last,
   input logic                  rsp_clipped_empty,
   input logic                  rsp_overflowed
);
   // empty result is a single, final transaction with zero coordinates
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped_empty |-> rsp_out_last && rsp_out_x == '0 && rsp_out_y == '0)
      else $error("empty result not final or not zero");

   // results never come back to back
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // a non-final result is followed by the next result of the stream, which is not empty
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> ##2 (rsp_valid && !rsp_clipped_empty))
      else $error("result stream broken");

   // overflow flag is the same on every result of one polygon
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |-> ##2 (rsp_overflowed == $past(rsp_overflowed, 2)))
      else $error("overflow flag changed within polygon");
endmodule

bind polygon_rect_clipper prc_checker #(.COORD_BITS(COORD_BITS)) u_prc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_out_x         (rsp_out_x),
   .rsp_out_y         (rsp_out_y),
   .rsp_out_last      (rsp_out_last),
   .rsp_clipped_empty (rsp_clipped_empty),
   .rsp_overflowed    (rsp_overflowed)
);

### tb/sv/polygon_rect_clipper_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for polygon_rect_clipper: vertex transactions in, clipped vertices
// out, compared against a built-in Sutherland-Hodgman predictor. Depends on prc_pkg.
module polygon_rect_clipper_tb;
   import prc_pkg::*;

   localparam int MAX_VERTS  = 32;
   localparam int COORD_BITS = 16;
   localparam int CLK_HALF   = 6;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         final_v;
   } vertex_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
      logic                         empty;
      logic                         ovf;
   } clip_result_type;

   typedef struct {
      longint x;
      longint y;
   } point_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [COORD_BITS-1:0] req_vertex_x = '0;
   logic signed [COORD_BITS-1:0] req_vertex_y = '0;
   logic                         req_is_final_vertex = 1'b0;
   logic                         rsp_valid;
   logic signed [COORD_BITS-1:0] rsp_out_x;
   logic signed [COORD_BITS-1:0] rsp_out_y;
   logic                         rsp_out_last;
   logic                         rsp_clipped_empty;
   logic                         rsp_overflowed;
   logic                         csr_we = 1'b0;
   logic [1:0]                   csr_index = '0;
   logic [COORD_BITS-1:0]        csr_wdata = '0;

   polygon_rect_clipper #(
      .MAX_VERTS (MAX_VERTS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_vertex_x       (req_vertex_x),
      .req_vertex_y       (req_vertex_y),
      .req_is_final_vertex(req_is_final_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_out_x          (rsp_out_x),
      .rsp_out_y          (rsp_out_y),
      .rsp_out_last       (rsp_out_last),
      .rsp_clipped_empty  (rsp_clipped_empty),
      .rsp_overflowed     (rsp_overflowed),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // predictor's copy of the rectangle (reset values)
   longint bound_min_x = 0;
   longint bound_min_y = 0;
   longint bound_max_x = 32767;
   longint bound_max_y = 32767;

   // predictor's polygon being loaded / clipped
   point_type poly[$];
   bit        loss_seen = 1'b0;

   vertex_type      pending_vertices[$];   // filled by the stimulus block, drained by the driver
   clip_result_type expected_clips[$];     // oldest expectation at the front
   vertex_type      drive_v;
   int              idle_pct = 21;
   int              mismatches = 0;
   int              items_queued = 0;

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // generous time limit on the whole run
   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // round to nearest, ties away from zero, of p0 + (p1-p0)*num/den
   function automatic longint interp(longint p0, longint p1, longint num, longint den);
      longint diff, a, b, d, q;
      bit     neg;
      diff = p1 - p0;
      if (den == 0) return p0;
      neg = (diff < 0) != ((num < 0) != (den < 0));
      a = (diff < 0) ? -diff : diff;
      b = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (2 * a * b + d) / (2 * d);
      return neg ? p0 - q : p0 + q;
   endfunction

   function automatic bit on_keep_side(point_type p, logic [1:0] side);
      case (side)
         SIDE_BOTTOM: return p.y >= bound_min_y;
         SIDE_RIGHT:  return p.x <= bound_max_x;
         SIDE_TOP:    return p.y <= bound_max_y;
         default:     return p.x >= bound_min_x;
      endcase
   endfunction

   // keep points up to the store depth; beyond that the polygon is marked lossy
   function automatic void keep_point(point_type p, inout bit lost);
      if (poly.size() < MAX_VERTS) poly.insert(poly.size(), p);
      else lost = 1'b1;
   endfunction

   // one Sutherland-Hodgman pass against one bound, in place on poly
   function automatic void clip_side(logic [1:0] side, inout bit lost);
      point_type src[$];
      point_type c, nx, p;
      bit        ci, ni;
      longint    b;
      src = poly;
      poly.delete();
      for (int i = 0; i < src.size(); i++) begin
         c  = src[i];
         nx = src[(i + 1 < src.size()) ? i + 1 : 0];
         ci = on_keep_side(c, side);
         ni = on_keep_side(nx, side);
         if (ci) keep_point(c, lost);
         if (ci != ni) begin
            if (side == SIDE_BOTTOM || side == SIDE_TOP) begin
               b   = (side == SIDE_BOTTOM) ? bound_min_y : bound_max_y;
               p.y = b;
               p.x = interp(c.x, nx.x, b - c.y, nx.y - c.y);
            end else begin
               b   = (side == SIDE_RIGHT) ? bound_max_x : bound_min_x;
               p.x = b;
               p.y = interp(c.y, nx.y, b - c.x, nx.x - c.x);
            end
            keep_point(p, lost);
         end
      end
   endfunction

   // accepted vertex transaction: store it, and on the closing vertex clip and queue results
   function automatic void load_vertex(vertex_type v);
      point_type       p;
      clip_result_type r;
      bit              lost;
      p.x = v.x;
      p.y = v.y;
      if (poly.size() < MAX_VERTS) poly.insert(poly.size(), p);
      else loss_seen = 1'b1;
      if (!v.final_v) return;
      lost = loss_seen;
      clip_side(SIDE_BOTTOM, lost);
      clip_side(SIDE_RIGHT, lost);
      clip_side(SIDE_TOP, lost);
      clip_side(SIDE_LEFT, lost);
      r.ovf = lost;
      if (poly.size() == 0) begin
         r.x = '0; r.y = '0; r.last = 1'b1; r.empty = 1'b1;
         expected_clips.insert(expected_clips.size(), r);
      end else begin
         foreach (poly[k]) begin
            r.x     = poly[k].x[COORD_BITS-1:0];
            r.y     = poly[k].y[COORD_BITS-1:0];
            r.last  = (k == poly.size() - 1);
            r.empty = 1'b0;
            expected_clips.insert(expected_clips.size(), r);
         end
      end
      poly.delete();
      loss_seen = 1'b0;
   endfunction

   // ---------------------------------------------------------------- driver

   // holds a transaction while busy; otherwise may idle before presenting the next one
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            drive_v.x       = req_vertex_x;
            drive_v.y       = req_vertex_y;
            drive_v.final_v = req_is_final_vertex;
            load_vertex(drive_v);
         end
         if (start && busy) begin
            // hold
         end else if (pending_vertices.size() > 0 && $urandom_range(99) >= idle_pct) begin
            drive_v              = pending_vertices.pop_front();
            start               <= 1'b1;
            req_vertex_x        <= drive_v.x;
            req_vertex_y        <= drive_v.y;
            req_is_final_vertex <= drive_v.final_v;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // results are single-cycle strobes; each one must match the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_clips.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result x=%0d y=%0d last=%b empty=%b ovf=%b",
                        rsp_out_x, rsp_out_y, rsp_out_last, rsp_clipped_empty,
                        rsp_overflowed);
         end else begin
            automatic clip_result_type e = expected_clips.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_last !== e.last ||
                rsp_clipped_empty !== e.empty || rsp_overflowed !== e.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp x=%0d y=%0d last=%b empty=%b ovf=%b, ",
                            "got x=%0d y=%0d last=%b empty=%b ovf=%b"},
                           e.x, e.y, e.last, e.empty, e.ovf, rsp_out_x, rsp_out_y,
                           rsp_out_last, rsp_clipped_empty, rsp_overflowed);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_vertex(longint x, longint y, bit fin);
      vertex_type v;
      v.x = x[COORD_BITS-1:0];
      v.y = y[COORD_BITS-1:0];
      v.final_v = fin;
      pending_vertices.insert(pending_vertices.size(), v);
      items_queued++;
   endtask

   // rectangle write: config only changes while the block is idle
   task automatic write_bound(logic [1:0] idx, longint val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[COORD_BITS-1:0];
      // the register holds the low bits, read back as a signed coordinate
      case (idx)
         REG_MIN_X: bound_min_x = $signed(val[COORD_BITS-1:0]);
         REG_MIN_Y: bound_min_y = $signed(val[COORD_BITS-1:0]);
         REG_MAX_X: bound_max_x = $signed(val[COORD_BITS-1:0]);
         default:   bound_max_y = $signed(val[COORD_BITS-1:0]);
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_rect(longint x0, longint y0, longint x1, longint y1);
      write_bound(REG_MIN_X, x0);
      write_bound(REG_MIN_Y, y0);
      write_bound(REG_MAX_X, x1);
      write_bound(REG_MAX_Y, y1);
   endtask

   // wait until every transaction is sent and every result seen, then let the engine settle
   task automatic drain();
      while (pending_vertices.size() > 0 || expected_clips.size() > 0 || start || busy)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // coordinate mostly near the rectangle, sometimes anywhere in range
   function automatic longint pick_coord(longint lo, longint hi);
      longint a, b, span, v;
      if ($urandom_range(3) == 0) return $signed(16'($urandom));
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      span = b - a + 1;
      v = a - span / 4 + longint'($urandom % (span * 3 / 2 + 1));
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   task automatic add_random_polygons(int n_items);
      int target, nv;
      target = items_queued + n_items;
      while (items_queued < target) begin
         // mostly small polygons; now and then a large one that nearly fills or overruns the store
         nv = ($urandom_range(11) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 7);
         for (int i = 0; i < nv; i++)
            add_vertex(pick_coord(bound_min_x, bound_max_x),
                       pick_coord(bound_min_y, bound_max_y), i == nv - 1);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset rectangle [0,32767]^2
      add_vertex(10, 10, 0); add_vertex(200, 10, 0); add_vertex(100, 300, 1);   // inside
      add_vertex(-100, -100, 0); add_vertex(500, -50, 0); add_vertex(50, 400, 1); // crossings
      add_vertex(-5, -5, 0); add_vertex(-500, -9, 0); add_vertex(-9, -700, 1);   // empty
      add_vertex(0, 0, 1);                                                       // one vertex on corner
      add_vertex(0, 32767, 0); add_vertex(32767, 0, 1);                          // two, on bounds
      add_vertex(-32768, -32768, 0); add_vertex(32767, 32767, 0);
      add_vertex(-32768, 32767, 0); add_vertex(32767, -32768, 1);                // extremes
      add_vertex(-1, 5, 0); add_vertex(3, -1, 0); add_vertex(7, 9, 1);           // rounding ties
      add_random_polygons(15);
      drain();

      set_rect(-32768, -32768, 32767, 32767);                                    // whole range
      add_random_polygons(20);
      drain();

      idle_pct = 73;
      set_rect(-1000, -500, 1500, 800);
      add_random_polygons(25);
      drain();

      set_rect(100, 50, -100, -50);                                              // inverted
      add_vertex(0, 0, 0); add_vertex(10, 0, 0); add_vertex(0, 10, 1);
      add_random_polygons(10);
      drain();

      idle_pct = 0;
      set_rect(0, 0, 0, 0);                                                      // degenerate
      add_vertex(-10, -10, 0); add_vertex(10, -10, 0); add_vertex(10, 10, 0);
      add_vertex(-10, 10, 1);
      add_random_polygons(8);
      drain();

      set_rect(-$urandom_range(20000), -$urandom_range(20000),
               $urandom_range(20000), $urandom_range(20000));
      add_random_polygons(25);
      drain();

      if (mismatches == 0 && expected_clips.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/prc_pkg.sv
rtl/prc_front.sv
rtl/prc_fifo.sv
rtl/prc_interp.sv
rtl/prc_back.sv
rtl/polygon_rect_clipper.sv
rtl/prc_checker.sv
tb/sv/polygon_rect_clipper_tb.sv
